### sv/bbc_pkg.sv
// Shared types, constants and the byte classifier for the bracket balance checker.
package bbc_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

	// op queue between front and back; depth must be a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_LROUND  = 8'h28; // (
	localparam logic [7:0] CH_RROUND  = 8'h29; // )
	localparam logic [7:0] CH_LCURLY  = 8'h7B; // {
	localparam logic [7:0] CH_RCURLY  = 8'h7D; // }
	localparam logic [7:0] CH_LSQUARE = 8'h5B; // [
	localparam logic [7:0] CH_RSQUARE = 8'h5D; // ]

	typedef enum logic [1:0] {
		KIND_ROUND,
		KIND_CURLY,
		KIND_SQUARE
	} kind_t;

	typedef enum logic [1:0] {
		OP_IGNORE,
		OP_OPEN,
		OP_CLOSE
	} op_code_t;

	typedef struct packed {
		op_code_t code;
		kind_t    kind;
		logic     last;
	} op_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic op_t classify(input logic [7:0] c, input logic l);
		op_t op;
		op.code = OP_IGNORE;
		op.kind = KIND_ROUND;
		op.last = l;
		case (c)
			CH_LROUND: begin
				op.code = OP_OPEN;
				op.kind = KIND_ROUND;
			end
			CH_LCURLY: begin
				op.code = OP_OPEN;
				op.kind = KIND_CURLY;
			end
			CH_LSQUARE: begin
				op.code = OP_OPEN;
				op.kind = KIND_SQUARE;
			end
			CH_RROUND: begin
				op.code = OP_CLOSE;
				op.kind = KIND_ROUND;
			end
			CH_RCURLY: begin
				op.code = OP_CLOSE;
				op.kind = KIND_CURLY;
			end
			CH_RSQUARE: begin
				op.code = OP_CLOSE;
				op.kind = KIND_SQUARE;
			end
			default: begin
				op.code = OP_IGNORE;
			end
		endcase
		return op;
	endfunction

endpackage

### sv/bbc_front.sv
// Front end: takes input requests and decodes each byte into a stack op.
module bbc_front import bbc_pkg::*; (
	input  logic       push,
	input  logic [7:0] ch,
	input  logic       last,
	input  q_stat_t    q_stat,
	output logic       q_push,
	output op_t        q_op
);

	assign q_push = push && !q_stat.full;
	assign q_op   = classify(ch, last);

endmodule

### sv/bbc_queue.sv
// Short op queue that decouples the decoder from the stack engine.
module bbc_queue import bbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_push,
	input  op_t     q_op,
	input  logic    q_pop,
	output op_t     head,
	output q_stat_t q_stat
);

	op_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_stat.empty = (cnt_q == '0);
	assign q_stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign head         = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (q_push) begin
			slot_q[wp_q] <= q_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			case ({q_push, q_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/bbc_back.sv
// Back end: kind stack in memory with a cached top, error flags and result register.
module bbc_back import bbc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  op_t  head,
	output logic q_pop,
	input  logic pop,
	output logic empty,
	output logic valid_res,
	output logic overflowed
);

	kind_t              mem [STACK_DEPTH];
	kind_t              rd_q;
	kind_t              top_q;
	kind_t              below_q;
	logic               below_sel_q;
	kind_t              below;
	logic [DEPTH_W-1:0] depth_q;
	logic               mis_q;
	logic               ovf_q;
	logic               res_valid_q;
	logic               res_ok_q;
	logic               res_ovf_q;

	logic               res_pop;
	logic               exec;
	logic               do_push;
	logic               do_pop;
	logic [DEPTH_W-1:0] depth_n;
	logic               mis_n;
	logic               ovf_n;
	logic [STACK_AW-1:0] raddr;

	// entry under the top: straight from the old top after a push, from memory after a pop
	assign below   = below_sel_q ? rd_q : below_q;
	assign res_pop = pop && res_valid_q;
	assign exec    = head_valid && (!head.last || !res_valid_q || res_pop);
	assign q_pop   = exec;
	assign raddr   = STACK_AW'(depth_q - DEPTH_W'(3));

	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		mis_n   = mis_q;
		ovf_n   = ovf_q;
		depth_n = depth_q;
		if (exec && !mis_q && !ovf_q) begin
			case (head.code)
				OP_OPEN: begin
					if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
						ovf_n = 1'b1;
					end else begin
						do_push = 1'b1;
						depth_n = depth_q + DEPTH_W'(1);
					end
				end
				OP_CLOSE: begin
					if (depth_q == '0 || top_q != head.kind) begin
						mis_n = 1'b1;
					end else begin
						do_pop  = 1'b1;
						depth_n = depth_q - DEPTH_W'(1);
					end
				end
				OP_IGNORE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[depth_q[STACK_AW-1:0]] <= head.kind;
		end
		if (do_pop) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			top_q   <= head.kind;
			below_q <= top_q;
		end else if (do_pop) begin
			top_q <= below;
		end
		if (exec && head.last) begin
			res_ok_q  <= !mis_n && !ovf_n && (depth_n == '0);
			res_ovf_q <= ovf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			mis_q       <= 1'b0;
			ovf_q       <= 1'b0;
			below_sel_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_push) begin
				below_sel_q <= 1'b0;
			end else if (do_pop) begin
				below_sel_q <= 1'b1;
			end
			if (exec && head.last) begin
				depth_q     <= '0;
				mis_q       <= 1'b0;
				ovf_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else begin
				if (exec) begin
					depth_q <= depth_n;
					mis_q   <= mis_n;
					ovf_q   <= ovf_n;
				end
				if (res_pop) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	assign empty      = !res_valid_q;
	assign valid_res  = res_ok_q;
	assign overflowed = res_ovf_q;

endmodule

### sv/bracket_balance_checker.sv
// Top level of the bracket balance checker: decoder, op queue and stack engine.
//
// Usage
//   Input queue port: one byte of text per request on ch, with last set on the
//   final byte of a string. A request is taken at a clock edge with push high
//   and full low. Result queue port: one request per string, shown while empty
//   is low and taken at an edge with pop high. valid_res says the string was
//   balanced, overflowed says nesting went past the stack depth.
// Throughput: one byte per cycle unless stalled. Every byte is a single push,
//   pop-compare or no-op on a stack whose top sits in a register; the entry
//   below the top is kept ready (old top after a push, one registered memory
//   read after a pop).
// Path of a final byte: queue slot, stack engine, result register, result port.
// Stall: the result register holds one result; while it is not taken, the
//   engine stops at the next final byte and the 4-entry op queue fills, then
//   full rises. Bytes ahead of that final byte keep flowing meanwhile.
// Reset: arst_n clears the depth count, error flags, queue and result state at
//   once; the stack memory itself is not cleared and needs no sweep, since
//   only entries below the depth count are ever used.
module bracket_balance_checker import bbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic       valid_res,
	output logic       overflowed
);

	q_stat_t q_stat;
	logic    q_push;
	op_t     q_op;
	logic    q_pop;
	op_t     q_head;

	bbc_front u_front (
		.push   (push),
		.ch     (ch),
		.last   (last),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_op   (q_op)
	);

	bbc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_op   (q_op),
		.q_pop  (q_pop),
		.head   (q_head),
		.q_stat (q_stat)
	);

	bbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_stat.empty),
		.head       (q_head),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.valid_res  (valid_res),
		.overflowed (overflowed)
	);

	assign full = q_stat.full;

	// engine only consumes a queued op
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("op queue popped while empty");

	// an accepted byte is waiting in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !q_stat.empty)
		else $error("accepted byte missing from op queue");

	// a new result only appears after a final byte was executed
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(q_pop && q_head.last))
		else $error("result appeared without a final byte");

	// an overflowed string can never be reported as balanced
	a_ovf_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(valid_res && overflowed))
		else $error("balanced result flagged as overflowed");

endmodule
